// File: hdl/ppsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppsa_pkg;

	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// field widths of the stream words
	localparam int OP_W   = 2;
	localparam int PRIO_W = 16;
	localparam int TGT_W  = 6;
	localparam int FCNT_W = 7;
	localparam int LIM_W  = 7;
	localparam int OUT_W  = 7;

	localparam logic [OP_W-1:0] OP_REQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_REL  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE = 2'd2;

	// broadcast from the sequencer to every slot cell
	typedef struct packed {
		logic              set;      // mark busy and load priority
		logic              clr;      // free
		logic [IDX_W-1:0]  idx;
		logic [PRIO_W-1:0] prio;
		logic [TGT_W-1:0]  tgt;      // release target, sampled by the scan
		logic              lim_clr;  // limit write: drop slots at or above usable
		logic [CNT_W-1:0]  usable;
	} slot_cmd_t;

	// scan word handed from cell to cell
	typedef struct packed {
		logic                     free_hit;
		logic [IDX_W-1:0]         free_idx;
		logic                     busy_hit;
		logic signed [PRIO_W-1:0] min_prio;
		logic [IDX_W-1:0]         min_idx;
		logic [CNT_W-1:0]         count;
		logic                     tgt_busy;
	} scan_t;

endpackage
`default_nettype wire

// File: hdl/ppsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ppsa_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ppsa_pkg::IDX_W-1:0] idx,
	input  wire ppsa_pkg::slot_cmd_t       cmd,
	input  wire ppsa_pkg::scan_t           scan_in,
	output ppsa_pkg::scan_t                scan_out
);

	logic                              busy_q;
	logic signed [ppsa_pkg::PRIO_W-1:0] prio_q;
	ppsa_pkg::scan_t                   scan_d;
	ppsa_pkg::scan_t                   scan_q;
	logic                              hit;
	logic                              en;

	assign hit = (cmd.idx == idx);
	assign en  = (ppsa_pkg::CNT_W'(idx) < cmd.usable);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.lim_clr && !en) begin
			busy_q <= 1'b0;
		end else if (cmd.set && hit) begin
			busy_q <= 1'b1;
		end else if (cmd.clr && hit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set && hit) begin
			prio_q <= cmd.prio;
		end
	end

	// first free wins; strictly smaller priority replaces, so ties keep the lower index
	always_comb begin
		scan_d = scan_in;
		if (!busy_q && en && !scan_in.free_hit) begin
			scan_d.free_hit = 1'b1;
			scan_d.free_idx = idx;
		end
		if (busy_q && (!scan_in.busy_hit || (prio_q < scan_in.min_prio))) begin
			scan_d.busy_hit = 1'b1;
			scan_d.min_prio = prio_q;
			scan_d.min_idx  = idx;
		end
		if (busy_q) begin
			scan_d.count = scan_in.count + ppsa_pkg::CNT_W'(1);
		end
		if (busy_q && (ppsa_pkg::TGT_W'(idx) == cmd.tgt)) begin
			scan_d.tgt_busy = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

	assign scan_out = scan_q;

endmodule
`default_nettype wire

// File: hdl/priority_preemptive_slot_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Signals                        | Contents
// s_*      | in  | s_tvalid s_tready s_tdata[31:0] | request, release or free-lowest word
// m_*      | out | m_tvalid m_tready m_tdata[23:0] | one result word per input word
// cfg_*    | in  | cfg_we cfg_data[6:0]           | slot_limit; the user writes it only while idle (not enforced)
//
// A word is handled as one scan along the cell row, then a decide step.
// Free-lowest repeats the scan and the decide step once per slot freed.
// The scan wave moves one cell per cycle.
// Reset clears all busy marks and sets the limit to SLOTS; no clearing pass.
// A finished result waits in the output register; the next word is taken meanwhile
// and only its own result waits on m_tready.
module priority_preemptive_slot_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] operation, [17:2] priority_req, [23:18] target_slot,
	// [30:24] free_count, [31] zero
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] ok, [6:1] granted_slot, [7] preempted, [14:8] released_count,
	// [21:15] active_count, [23:22] zero
	output logic [23:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_data
);

	localparam int IDX_W = ppsa_pkg::IDX_W;
	localparam int CNT_W = ppsa_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t state_q;

	// latched input word
	logic [ppsa_pkg::OP_W-1:0]          op_q;
	logic signed [ppsa_pkg::PRIO_W-1:0] preq_q;
	logic [ppsa_pkg::TGT_W-1:0]         tgt_q;
	logic [ppsa_pkg::FCNT_W-1:0]        rem_q;   // free-lowest budget left
	logic [ppsa_pkg::OUT_W-1:0]         rel_q;   // slots freed so far

	logic [IDX_W-1:0] cnt_q;                    // scan cycle counter
	logic [CNT_W-1:0] usable_q;
	logic [CNT_W-1:0] usable_new;

	ppsa_pkg::slot_cmd_t cmd;
	ppsa_pkg::scan_t     scan_w [ppsa_pkg::SLOTS+1];
	ppsa_pkg::scan_t     res;

	// result register
	logic                       m_tvalid_q;
	logic                       ok_q;
	logic [IDX_W-1:0]           gnt_q;
	logic                       pre_q;
	logic [ppsa_pkg::OUT_W-1:0] relo_q;
	logic [ppsa_pkg::OUT_W-1:0] act_q;

	// decide-cycle outcome
	logic                       fin;
	logic                       out_free;
	logic                       do_set;
	logic                       do_clr;
	logic [IDX_W-1:0]           wr_idx;
	logic                       ok_d;
	logic [IDX_W-1:0]           gnt_d;
	logic                       pre_d;
	logic [ppsa_pkg::OUT_W-1:0] relo_d;
	logic [ppsa_pkg::OUT_W-1:0] act_d;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign res      = scan_w[ppsa_pkg::SLOTS];

	// usable = min(slot_limit, SLOTS)
	assign usable_new = (int'(cfg_data) < ppsa_pkg::SLOTS) ? CNT_W'(cfg_data)
	                                                       : CNT_W'(ppsa_pkg::SLOTS);

	// seed of the scan wave: nothing found, no busy slots counted
	assign scan_w[0] = '0;

	for (genvar g = 0; g < ppsa_pkg::SLOTS; g++) begin : g_row
		ppsa_cell u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(g)),
			.cmd     (cmd),
			.scan_in (scan_w[g]),
			.scan_out(scan_w[g+1])
		);
	end

	always_comb begin
		fin    = 1'b1;
		do_set = 1'b0;
		do_clr = 1'b0;
		wr_idx = res.min_idx;
		ok_d   = 1'b0;
		gnt_d  = '0;
		pre_d  = 1'b0;
		relo_d = '0;
		act_d  = ppsa_pkg::OUT_W'(res.count);
		case (op_q)
			ppsa_pkg::OP_REQ: begin
				if (res.free_hit) begin
					do_set = 1'b1;
					wr_idx = res.free_idx;
					ok_d   = 1'b1;
					gnt_d  = res.free_idx;
					act_d  = ppsa_pkg::OUT_W'(res.count) + ppsa_pkg::OUT_W'(1);
				end else if (res.busy_hit && (res.min_prio < preq_q)) begin
					do_set = 1'b1;
					ok_d   = 1'b1;
					gnt_d  = res.min_idx;
					pre_d  = 1'b1;
				end
			end
			ppsa_pkg::OP_REL: begin
				if (res.tgt_busy) begin
					do_clr = 1'b1;
					wr_idx = IDX_W'(tgt_q);
					ok_d   = 1'b1;
					relo_d = ppsa_pkg::OUT_W'(1);
					act_d  = ppsa_pkg::OUT_W'(res.count) - ppsa_pkg::OUT_W'(1);
				end
			end
			ppsa_pkg::OP_FREE: begin
				if ((rem_q != '0) && res.busy_hit) begin
					fin    = 1'b0;
					do_clr = 1'b1;
				end else begin
					ok_d   = (rel_q != '0);
					relo_d = rel_q;
				end
			end
			default: begin
			end
		endcase
	end

	// writes to the row only land when the result can be stored too, except free-lowest clears, which do not wait
	always_comb begin
		cmd.set     = (state_q == ST_DECIDE) && do_set && out_free;
		cmd.clr     = (state_q == ST_DECIDE) && do_clr && (out_free || !fin);
		cmd.idx     = wr_idx;
		cmd.prio    = preq_q;
		cmd.tgt     = tgt_q;
		cmd.lim_clr = cfg_we;
		cmd.usable  = cfg_we ? usable_new : usable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			usable_q   <= CNT_W'(ppsa_pkg::SLOTS);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				usable_q <= usable_new;
			end
			// a new result replaces the old one only once the old one has gone
			if ((state_q == ST_DECIDE) && fin && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == IDX_W'(ppsa_pkg::SLOTS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!fin) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tdata[1:0];
			preq_q <= s_tdata[17:2];
			tgt_q  <= s_tdata[23:18];
			rem_q  <= s_tdata[30:24];
			rel_q  <= '0;
		end else if ((state_q == ST_DECIDE) && !fin) begin
			rem_q <= rem_q - ppsa_pkg::FCNT_W'(1);
			rel_q <= rel_q + ppsa_pkg::OUT_W'(1);
		end
		if ((state_q == ST_DECIDE) && fin && out_free) begin
			ok_q   <= ok_d;
			gnt_q  <= gnt_d;
			pre_q  <= pre_d;
			relo_q <= relo_d;
			act_q  <= act_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, act_q, relo_q, pre_q, ppsa_pkg::TGT_W'(gnt_q), ok_q};

endmodule
`default_nettype wire

// File: hdl/ppsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ppsa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[21:15]) <= ppsa_pkg::SLOTS))
		else $error("active count above pool size");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |->
			(m_tdata[6:1] == 6'd0) && !m_tdata[7] && (m_tdata[14:8] == 7'd0))
		else $error("refused word carries a grant or release");

	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[0] && (m_tdata[14:8] == 7'd0))
		else $error("preemption without grant or with release");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[14:8] != 7'd0) |->
			m_tdata[0] && !m_tdata[7] && (m_tdata[6:1] == 6'd0))
		else $error("release word carries a grant");

endmodule

bind priority_preemptive_slot_allocator_core ppsa_checker u_ppsa_checker (.*);
`default_nettype wire
